// ----- design/vox_voxel_stream_parser_unit_defines.svh -----
// Assertion macros for the voxel stream parser.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef VOX_VOXEL_STREAM_PARSER_UNIT_DEFINES_SVH
`define VOX_VOXEL_STREAM_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define VOX_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
`define VOX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`define VOX_ASSERT_DLY2(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##2 (cons)) \
    else $error(msg);
`else
`define VOX_ASSERT(lbl, cond, msg)
`define VOX_ASSERT_NEXT(lbl, ante, cons, msg)
`define VOX_ASSERT_DLY2(lbl, ante, cons, msg)
`endif

`endif

// ----- design/vox_pkg.sv -----
// Shared types, codes and constants of the voxel stream parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package vox_pkg;

  // result kinds
  localparam logic [1:0] KIND_VOXEL  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // error codes
  localparam logic [1:0] ERR_HEADER  = 2'd0;
  localparam logic [1:0] ERR_NO_SIZE = 2'd1;
  localparam logic [1:0] ERR_NO_XYZI = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_OFFSET_X = 2'd0;
  localparam logic [1:0] CFG_OFFSET_Y = 2'd1;
  localparam logic [1:0] CFG_OFFSET_Z = 2'd2;

  // parser phases
  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_HDR   = 4'd1;
  localparam logic [3:0] PH_FIRST = 4'd2;
  localparam logic [3:0] PH_PACK  = 4'd3;
  localparam logic [3:0] PH_SIZET = 4'd4;
  localparam logic [3:0] PH_SIZEB = 4'd5;
  localparam logic [3:0] PH_XYZI  = 4'd6;
  localparam logic [3:0] PH_VOX   = 4'd7;
  localparam logic [3:0] PH_PEND  = 4'd8;

  // little-endian tags and lengths
  localparam logic [31:0] TAG_VOX     = 32'h2058_4F56;
  localparam logic [31:0] TAG_PACK    = 32'h4B43_4150;
  localparam logic [31:0] TAG_SIZE    = 32'h455A_4953;
  localparam logic [31:0] TAG_XYZI    = 32'h495A_5958;
  localparam logic [31:0] VOX_VERSION = 32'd150;
  localparam logic [4:0]  HDR_LAST    = 5'd19;  // header is 20 bytes
  localparam logic [4:0]  SIZE_LAST   = 5'd23;  // SIZE chunk is 24 bytes
  localparam logic [4:0]  CHUNK_LAST  = 5'd15;  // chunk header is 16 bytes

  localparam int VOX_FIFO_DEPTH = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } vox_in_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [30:0]        frame_index;
    logic [31:0]        item_count;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [7:0]         color_index;
    logic [1:0]         error_code;
  } vox_out_t;

  // classified item handed from front to back, coordinates still raw
  typedef struct packed {
    logic [1:0]  kind;
    logic [30:0] frame_index;
    logic [31:0] item_count;
    logic [7:0]  raw_x;
    logic [7:0]  raw_y;
    logic [7:0]  raw_z;
    logic [7:0]  color_index;
    logic [1:0]  error_code;
  } vox_cmd_t;

  typedef struct packed {
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic signed [15:0] offset_z;
  } vox_offsets_t;

  typedef struct packed {
    logic full;
    logic empty;
  } vox_fifo_status_t;

endpackage

`default_nettype wire

// ----- design/vox_parser_front.sv -----
// Front end: byte-serial file parser that turns the transfers of a file into commands.
// Depends on vox_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vox_parser_front import vox_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     accept_i,
  input  wire vox_in_t  in_data_i,
  output logic          push_o,
  output vox_cmd_t      cmd_o,
  output logic [3:0]    phase_o
);

  logic [3:0]  phase_q, phase_d;
  logic [4:0]  pos_q, pos_d;
  logic [31:0] ws_q, ws_d;
  logic [31:0] ft_q, ft_d;
  logic [31:0] fc_q, fc_d;
  logic [31:0] vl_q, vl_d;
  logic [23:0] rb_q, rb_d;
  logic        bad_q, bad_d;

  always_comb begin
    logic [7:0] b;
    logic       sof;
    logic       was_pend;
    b        = in_data_i.data_byte;
    sof      = in_data_i.start_of_file;
    was_pend = (phase_q == PH_PEND);
    phase_d  = phase_q;
    pos_d    = pos_q;
    ws_d     = ws_q;
    ft_d     = ft_q;
    fc_d     = fc_q;
    vl_d     = vl_q;
    rb_d     = rb_q;
    bad_d    = bad_q;
    push_o   = 1'b0;
    cmd_o    = '0;

    if (accept_i) begin
      if (was_pend) begin
        push_o           = 1'b1;
        cmd_o.kind       = KIND_DONE;
        cmd_o.item_count = ft_q;
        phase_d          = PH_IDLE;
      end
      if (sof) begin
        phase_d = PH_HDR;
        pos_d   = '0;
        ws_d    = '0;
        ft_d    = 32'd1;
        fc_d    = '0;
        vl_d    = '0;
        rb_d    = '0;
        bad_d   = 1'b0;
      end
      if (phase_d != PH_IDLE && !(was_pend && !sof)) begin
        ws_d = {b, ws_d[31:8]};
        unique case (phase_d)
          PH_HDR: begin
            if (pos_d == 5'd3 && ws_d != TAG_VOX) bad_d = 1'b1;
            if (pos_d == 5'd7 && (bad_d || ws_d != VOX_VERSION)) begin
              phase_d          = PH_IDLE;
              push_o           = 1'b1;
              cmd_o.kind       = KIND_ERROR;
              cmd_o.error_code = ERR_HEADER;
            end else if (pos_d == HDR_LAST) begin
              phase_d = PH_FIRST;
              pos_d   = '0;
            end else begin
              pos_d = pos_d + 5'd1;
            end
          end
          PH_FIRST, PH_SIZET: begin
            if (pos_d < 5'd3) begin
              pos_d = pos_d + 5'd1;
            end else if (phase_d == PH_FIRST && ws_d == TAG_PACK) begin
              phase_d = PH_PACK;
              pos_d   = 5'd4;
            end else if (ws_d == TAG_SIZE) begin
              phase_d = PH_SIZEB;
              pos_d   = 5'd4;
            end else begin
              phase_d           = PH_IDLE;
              push_o            = 1'b1;
              cmd_o.kind        = KIND_ERROR;
              cmd_o.frame_index = fc_d[30:0];
              cmd_o.error_code  = ERR_NO_SIZE;
            end
          end
          PH_PACK: begin
            if (pos_d == CHUNK_LAST) begin
              ft_d  = ws_d;
              pos_d = '0;
              if (ws_d == 32'd0) begin
                phase_d    = PH_IDLE;
                push_o     = 1'b1;
                cmd_o.kind = KIND_DONE;
              end else begin
                phase_d = PH_SIZET;
              end
            end else begin
              pos_d = pos_d + 5'd1;
            end
          end
          PH_SIZEB: begin
            if (pos_d == SIZE_LAST) begin
              phase_d = PH_XYZI;
              pos_d   = '0;
            end else begin
              pos_d = pos_d + 5'd1;
            end
          end
          PH_XYZI: begin
            if (pos_d == 5'd3 && ws_d != TAG_XYZI) begin
              phase_d           = PH_IDLE;
              push_o            = 1'b1;
              cmd_o.kind        = KIND_ERROR;
              cmd_o.frame_index = fc_d[30:0];
              cmd_o.error_code  = ERR_NO_XYZI;
            end else if (pos_d == CHUNK_LAST) begin
              vl_d              = ws_d;
              pos_d             = '0;
              push_o            = 1'b1;
              cmd_o.kind        = KIND_HEADER;
              cmd_o.frame_index = fc_d[30:0];
              cmd_o.item_count  = ws_d;
              if (ws_d == 32'd0) begin
                fc_d    = fc_d + 32'd1;
                phase_d = (fc_d == ft_d) ? PH_PEND : PH_SIZET;
              end else begin
                phase_d = PH_VOX;
              end
            end else begin
              pos_d = pos_d + 5'd1;
            end
          end
          PH_VOX: begin
            if (pos_d < 5'd3) begin
              rb_d  = {rb_d[15:0], b};
              pos_d = pos_d + 5'd1;
            end else begin
              push_o            = 1'b1;
              cmd_o.kind        = KIND_VOXEL;
              cmd_o.frame_index = fc_d[30:0];
              cmd_o.raw_z       = rb_d[23:16];
              cmd_o.raw_x       = rb_d[15:8];
              cmd_o.raw_y       = rb_d[7:0];
              cmd_o.color_index = b;
              rb_d              = '0;
              pos_d             = '0;
              vl_d              = vl_d - 32'd1;
              if (vl_d == 32'd0) begin
                fc_d    = fc_d + 32'd1;
                phase_d = (fc_d == ft_d) ? PH_PEND : PH_SIZET;
              end
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pos_q   <= '0;
      ws_q    <= '0;
      ft_q    <= 32'd1;
      fc_q    <= '0;
      vl_q    <= '0;
      rb_q    <= '0;
      bad_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      ws_q    <= ws_d;
      ft_q    <= ft_d;
      fc_q    <= fc_d;
      vl_q    <= vl_d;
      rb_q    <= rb_d;
      bad_q   <= bad_d;
    end
  end

  assign phase_o = phase_q;

endmodule

`default_nettype wire

// ----- design/vox_cmd_fifo.sv -----
// Short command queue between the parser front end and the result back end.
// Depends on vox_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vox_cmd_fifo import vox_pkg::*; #(
  parameter int Depth = VOX_FIFO_DEPTH  // at least 2
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire vox_cmd_t   push_data_i,
  input  wire logic       pop_i,
  output vox_cmd_t        pop_data_o,
  output vox_fifo_status_t status_o
);

  localparam int AW = $clog2(Depth);
  localparam int CW = $clog2(Depth + 1);

  vox_cmd_t        mem_q [Depth];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + CW'(1);
      2'b01:   count_d = count_q - CW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o     = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == CW'(Depth));
  assign status_o.empty = (count_q == '0);

endmodule

`default_nettype wire

// ----- design/vox_result_back.sv -----
// Back end: pops commands, adds the coordinate offsets, holds the output register.
// Depends on vox_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vox_result_back import vox_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire vox_fifo_status_t fifo_status_i,
  input  wire vox_cmd_t         cmd_i,
  output logic                  pop_o,
  input  wire vox_offsets_t     offsets_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output vox_out_t              out_data_o
);

  logic     valid_q, valid_d;
  vox_out_t data_q, data_d;

  assign pop_o = !fifo_status_i.empty && (!valid_q || !out_stall_i);

  always_comb begin
    data_d             = '0;
    data_d.result_kind = cmd_i.kind;
    data_d.frame_index = cmd_i.frame_index;
    data_d.item_count  = cmd_i.item_count;
    data_d.color_index = cmd_i.color_index;
    data_d.error_code  = cmd_i.error_code;
    if (cmd_i.kind == KIND_VOXEL) begin
      data_d.pos_x = offsets_i.offset_x + $signed({8'h00, cmd_i.raw_x});
      data_d.pos_y = offsets_i.offset_y + $signed({8'h00, cmd_i.raw_y});
      data_d.pos_z = offsets_i.offset_z + $signed({8'h00, cmd_i.raw_z});
    end
    valid_d = pop_o ? 1'b1 : (valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

// ----- design/vox_voxel_stream_parser_unit.sv -----
// Top level of the voxel stream parser: front end, command queue, back end, offsets.
// Depends on vox_pkg, vox_parser_front, vox_cmd_fifo, vox_result_back and the defines header.
//
// Usage
//   Input channel (in_valid_i / in_stall_o / in_data_i): one file byte per transfer,
//   start_of_file set on byte zero of every file. Output channel (out_valid_o /
//   out_stall_i / out_data_o): voxel, frame header, done and error results.
//   Configuration: cfg_we_i writes cfg_wdata_i into offset x, y or z by cfg_index_i;
//   index 3 is ignored. Write only while the block is idle.
// Throughput: one byte per cycle while in_stall_o is low; the parser phase is registered per accepted byte.
// Path: a result passes the command queue and then the output register before it shows on
//   out_valid_o; an output stall holds it in the queue. The done result after
//   the last frame is produced by the following byte, whatever it carries.
// Stall: the queue absorbs results while the receiver stalls; in_stall_o rises only
//   once the queue is full, so bytes that give no result still flow for a while.
// Reset: asynchronous, active low; parser idles until a start-of-file byte, offsets
//   clear to zero, queue and output register empty.
`timescale 1ns / 1ps
`default_nettype none
`include "vox_voxel_stream_parser_unit_defines.svh"

module vox_voxel_stream_parser_unit import vox_pkg::*; #(
  parameter int FifoDepth = VOX_FIFO_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire vox_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output vox_out_t         out_data_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_wdata_i
);

  vox_offsets_t     offsets_q;
  logic             in_accept;
  logic             front_push;
  vox_cmd_t         front_cmd;
  logic [3:0]       front_phase;
  vox_cmd_t         fifo_data;
  vox_fifo_status_t fifo_st;
  logic             back_pop;

  // offset registers; they are to be touched only while idle, which the block does not enforce
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offsets_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_OFFSET_X: offsets_q.offset_x <= cfg_wdata_i;
        CFG_OFFSET_Y: offsets_q.offset_y <= cfg_wdata_i;
        CFG_OFFSET_Z: offsets_q.offset_z <= cfg_wdata_i;
        default:      offsets_q <= offsets_q;
      endcase
    end
  end

  // the front end only stalls when the queue has no room for a result
  assign in_stall_o = fifo_st.full;
  assign in_accept  = in_valid_i && !in_stall_o;

  vox_parser_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_accept),
    .in_data_i (in_data_i),
    .push_o    (front_push),
    .cmd_o     (front_cmd),
    .phase_o   (front_phase)
  );

  vox_cmd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (front_push),
    .push_data_i (front_cmd),
    .pop_i       (back_pop),
    .pop_data_o  (fifo_data),
    .status_o    (fifo_st)
  );

  vox_result_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fifo_status_i (fifo_st),
    .cmd_i         (fifo_data),
    .pop_o         (back_pop),
    .offsets_i     (offsets_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

  // a result must never be pushed into a full queue
  `VOX_ASSERT(a_no_push_full, !front_push || !fifo_st.full, "push into full command queue")
  // an error result leaves the parser idle
  `VOX_ASSERT_NEXT(a_err_idle, front_push && front_cmd.kind == KIND_ERROR, front_phase == PH_IDLE, "parser not idle after error")
  // with both stages empty a result passes the queue and then the output register without waiting
  `VOX_ASSERT_DLY2(a_latency, front_push && fifo_st.empty && !out_valid_o, out_valid_o, "result not delivered in two cycles")

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for vox_voxel_stream_parser_unit: builds voxel files byte by byte,
// predicts every result in order and checks each output transfer field by field.
// Depends on vox_pkg and the block's RTL only.
`timescale 1ns / 1ps

module testbench;
  import vox_pkg::*;

  localparam logic [1:0] CFG_UNUSED   = 2'd3;  // index with no register behind it
  localparam logic [4:0] WORD_LAST    = 5'd3;  // last byte of a chunk tag or of the magic
  localparam logic [4:0] VERSION_LAST = 5'd7;  // last header byte of the version word
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 4;   // queue plus output register, with margin

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  vox_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  vox_out_t    out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  logic quiet = 1'b0;  // no pacing on either side once set
  int   errors, bytes_sent, results_seen, files_sent, idle_cycles;

  // parser state as the testbench sees it
  logic [3:0]   ph;
  logic [4:0]   bpos;
  logic [31:0]  shifter, frames_total, frame_cnt, vox_left;
  logic [23:0]  rec;
  logic         hdr_bad;
  vox_offsets_t offs;

  vox_out_t   expected_results[$];
  logic [7:0] file_q[$];

  vox_voxel_stream_parser_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------- prediction

  function automatic void clear_parse();
    bpos         = '0;
    shifter      = '0;
    frames_total = 32'd1;
    frame_cnt    = '0;
    vox_left     = '0;
    rec          = '0;
    hdr_bad      = 1'b0;
  endfunction

  function automatic vox_out_t result_of(input logic [1:0] kind, input logic [30:0] frame,
                                         input logic [31:0] count, input logic [1:0] code);
    vox_out_t r;
    r = '0;
    r.result_kind = kind;
    r.frame_index = frame;
    r.item_count  = count;
    r.error_code  = code;
    return r;
  endfunction

  function automatic void close_frame();
    frame_cnt++;
    bpos = '0;
    ph   = (frame_cnt == frames_total) ? PH_PEND : PH_SIZET;
  endfunction

  // One accepted byte: advance the parser and queue the result it gives, if any.
  function automatic void parse_byte(input logic [7:0] b, input logic sof);
    vox_out_t r;
    logic     got;
    r   = '0;
    got = 1'b0;
    // done after the last frame rides on whatever byte comes next
    if (ph == PH_PEND) begin
      r   = result_of(KIND_DONE, '0, frames_total, '0);
      got = 1'b1;
      ph  = PH_IDLE;
    end
    if (sof) begin
      clear_parse();
      ph = PH_HDR;
    end
    if (ph != PH_IDLE && (sof || !got)) begin
      shifter = {b, shifter[31:8]};
      case (ph)
        PH_HDR: begin
          if (bpos == WORD_LAST && shifter != TAG_VOX) hdr_bad = 1'b1;
          if (bpos == VERSION_LAST && (hdr_bad || shifter != VOX_VERSION)) begin
            ph  = PH_IDLE;
            r   = result_of(KIND_ERROR, '0, '0, ERR_HEADER);
            got = 1'b1;
          end else if (bpos == HDR_LAST) begin
            ph   = PH_FIRST;
            bpos = '0;
          end else begin
            bpos++;
          end
        end
        PH_FIRST, PH_SIZET: begin
          if (bpos < WORD_LAST) begin
            bpos++;
          end else if (ph == PH_FIRST && shifter == TAG_PACK) begin
            ph   = PH_PACK;
            bpos = WORD_LAST + 5'd1;
          end else if (shifter == TAG_SIZE) begin
            ph   = PH_SIZEB;
            bpos = WORD_LAST + 5'd1;
          end else begin
            ph  = PH_IDLE;
            r   = result_of(KIND_ERROR, frame_cnt[30:0], '0, ERR_NO_SIZE);
            got = 1'b1;
          end
        end
        PH_PACK: begin
          if (bpos == CHUNK_LAST) begin
            frames_total = shifter;
            bpos         = '0;
            if (shifter == '0) begin
              ph  = PH_IDLE;
              r   = result_of(KIND_DONE, '0, '0, '0);
              got = 1'b1;
            end else begin
              ph = PH_SIZET;
            end
          end else begin
            bpos++;
          end
        end
        PH_SIZEB: begin
          if (bpos == SIZE_LAST) begin
            ph   = PH_XYZI;
            bpos = '0;
          end else begin
            bpos++;
          end
        end
        PH_XYZI: begin
          if (bpos == WORD_LAST && shifter != TAG_XYZI) begin
            ph  = PH_IDLE;
            r   = result_of(KIND_ERROR, frame_cnt[30:0], '0, ERR_NO_XYZI);
            got = 1'b1;
          end else if (bpos == CHUNK_LAST) begin
            r        = result_of(KIND_HEADER, frame_cnt[30:0], shifter, '0);
            got      = 1'b1;
            vox_left = shifter;
            bpos     = '0;
            if (shifter == '0) close_frame();
            else ph = PH_VOX;
          end else begin
            bpos++;
          end
        end
        PH_VOX: begin
          // record is z, x, y, colour
          if (bpos < WORD_LAST) begin
            rec = {rec[15:0], b};
            bpos++;
          end else begin
            r             = result_of(KIND_VOXEL, frame_cnt[30:0], '0, '0);
            r.pos_x       = {8'h00, rec[15:8]} + offs.offset_x;
            r.pos_y       = {8'h00, rec[7:0]} + offs.offset_y;
            r.pos_z       = {8'h00, rec[23:16]} + offs.offset_z;
            r.color_index = b;
            got           = 1'b1;
            rec           = '0;
            bpos          = '0;
            vox_left--;
            if (vox_left == '0) close_frame();
          end
        end
        default: ph = PH_IDLE;
      endcase
    end
    if (got) expected_results.push_back(r);
  endfunction

  // ---------------------------------------------------------------- file building

  function automatic void put_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) file_q.push_back(w[8*i +: 8]);
  endfunction

  function automatic void put_junk(input int n);
    repeat (n) file_q.push_back(8'($urandom));
  endfunction

  function automatic void start_file(input logic [31:0] version);
    file_q.delete();
    put_word(TAG_VOX);
    put_word(version);
    put_junk(12);
  endfunction

  function automatic void put_pack(input logic [31:0] frames);
    put_word(TAG_PACK);
    put_junk(8);
    put_word(frames);
  endfunction

  // SIZE chunk then XYZI chunk header; tags passed in so they can be broken
  function automatic void put_frame(input logic [31:0] size_tag, input logic [31:0] xyzi_tag,
                                    input logic [31:0] voxels);
    put_word(size_tag);
    put_junk(20);
    put_word(xyzi_tag);
    put_junk(8);
    put_word(voxels);
  endfunction

  function automatic void put_voxel(input logic [7:0] z, input logic [7:0] x,
                                    input logic [7:0] y, input logic [7:0] c);
    file_q.push_back(z);
    file_q.push_back(x);
    file_q.push_back(y);
    file_q.push_back(c);
  endfunction

  // mostly well-formed, random content; now and then a damaged byte or a cut tail
  function automatic void build_random_file();
    int          frames;
    logic [31:0] n;
    start_file(VOX_VERSION);
    if ($urandom_range(0, 2) == 0) begin
      frames = $urandom_range(0, 3);
      put_pack(frames);
    end else begin
      frames = 1;
    end
    repeat (frames) begin
      n = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
      put_frame(TAG_SIZE, TAG_XYZI, n);
      put_junk(4 * n);
    end
    if ($urandom_range(0, 7) == 0)
      file_q[$urandom_range(0, file_q.size() - 1)] = 8'($urandom);
    if ($urandom_range(0, 9) == 0)
      file_q = file_q[0:$urandom_range(0, file_q.size() - 1)];
  endfunction

  function automatic logic [15:0] pick_offset();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------- driving

  // one input transfer; called and returns at a falling edge
  task automatic push_byte(input logic [7:0] b, input logic sof);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, start_of_file: sof};
    do @(posedge clk); while (in_stall);
    parse_byte(b, sof);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_file(input int pause_at);
    for (int i = 0; i < file_q.size(); i++) begin
      push_byte(file_q[i], i == 0);
      if (i == pause_at) quiesce(0);
    end
    files_sent++;
  endtask

  task automatic send_noise(input int n, input logic with_sof);
    repeat (n) push_byte(8'($urandom), with_sof && $urandom_range(0, 3) == 0);
  endtask

  // hold the input until every predicted result has been seen
  task automatic quiesce(input int extra);
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_results.size() != 0);
    repeat (extra) @(negedge clk);
  endtask

  task automatic set_offsets(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
    logic [15:0] vals[4];
    logic [1:0]  regs[4];
    quiesce(DRAIN_CYCLES);
    vals = '{x, y, z, 16'($urandom)};
    regs = '{CFG_OFFSET_X, CFG_OFFSET_Y, CFG_OFFSET_Z, CFG_UNUSED};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_wdata <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    offs.offset_x = x;
    offs.offset_y = y;
    offs.offset_z = z;
  endtask

  // ---------------------------------------------------------------- receiver pacing

  always begin : out_pacing
    int burst;
    if (quiet) begin
      out_stall <= 1'b0;
      @(negedge clk);
    end else begin
      burst = $urandom_range(1, 9);
      out_stall <= ($urandom_range(0, 2) == 0);
      repeat (burst) begin
        @(negedge clk);
        if (quiet) break;
      end
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic note_failure(input string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got)
      note_failure($sformatf("result %0d %s: expected %0h, got %0h", results_seen, name,
                             want, got));
  endtask

  always @(posedge clk) begin : result_check
    vox_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        note_failure($sformatf("result %0d arrived with none expected (kind %0d)",
                               results_seen, out_data.result_kind));
      end else begin
        want = expected_results.pop_front();
        cmp_field("result_kind", want.result_kind, out_data.result_kind);
        cmp_field("frame_index", want.frame_index, out_data.frame_index);
        cmp_field("item_count",  want.item_count,  out_data.item_count);
        cmp_field("pos_x",       want.pos_x,       out_data.pos_x);
        cmp_field("pos_y",       want.pos_y,       out_data.pos_y);
        cmp_field("pos_z",       want.pos_z,       out_data.pos_z);
        cmp_field("color_index", want.color_index, out_data.color_index);
        cmp_field("error_code",  want.error_code,  out_data.error_code);
      end
    end
  end

  // no transfer on either channel for too long means the block is stuck
  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: %0d cycles without a transfer, %0d results outstanding",
               idle_cycles, expected_results.size());
      $display("** vox_voxel_stream_parser_unit: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  // plain one-frame file, corner coordinates and colours, then idle bytes
  task automatic test_basic_frame();
    set_offsets(16'h0003, 16'hFFFE, 16'h0100);
    start_file(VOX_VERSION);
    put_frame(TAG_SIZE, TAG_XYZI, 3);
    put_voxel(8'h00, 8'h00, 8'h00, 8'h00);
    put_voxel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    put_voxel(8'hA5, 8'h01, 8'h80, 8'h7F);
    send_file(-1);
    send_noise(3, 1'b0);  // first one releases the done, the rest are ignored
  endtask

  task automatic test_header_errors();
    start_file(VOX_VERSION);
    file_q[3] = 8'h21;    // broken magic
    put_frame(TAG_SIZE, TAG_XYZI, 1);
    put_junk(4);
    send_file(-1);
    start_file(32'd151);  // wrong version
    send_file(-1);
    start_file(32'h0100_0096);  // right low byte, junk in the upper ones
    send_file(-1);
    start_file(VOX_VERSION);    // cut short inside the header, next file restarts
    file_q = file_q[0:4];
    send_file(-1);
  endtask

  task automatic test_chunk_errors();
    start_file(VOX_VERSION);    // first chunk neither PACK nor SIZE
    put_frame(TAG_XYZI, TAG_XYZI, 0);
    send_file(-1);
    start_file(VOX_VERSION);    // XYZI missing in the only frame
    put_frame(TAG_SIZE, TAG_SIZE, 0);
    send_file(-1);
    start_file(VOX_VERSION);    // PACK tag where the second SIZE belongs
    put_pack(3);
    put_frame(TAG_SIZE, TAG_XYZI, 1);
    put_junk(4);
    put_frame(TAG_PACK, TAG_XYZI, 0);
    send_file(-1);
    start_file(VOX_VERSION);    // XYZI missing in the third frame
    put_pack(3);
    put_frame(TAG_SIZE, TAG_XYZI, 0);
    put_frame(TAG_SIZE, TAG_XYZI, 1);
    put_junk(4);
    put_frame(TAG_SIZE, TAG_PACK, 0);
    send_file(-1);
  endtask

  task automatic test_frame_counts();
    start_file(VOX_VERSION);    // zero frames: done at the last PACK byte
    put_pack(0);
    send_file(-1);
    send_noise(2, 1'b0);
    start_file(VOX_VERSION);    // empty frame then a full one, paused half way
    put_pack(2);
    put_frame(TAG_SIZE, TAG_XYZI, 0);
    put_frame(TAG_SIZE, TAG_XYZI, 2);
    put_junk(8);
    send_file(70);
    start_file(VOX_VERSION);    // its first byte carries the pending done
    put_frame(TAG_SIZE, TAG_XYZI, 1);
    put_junk(4);
    send_file(-1);
    start_file(VOX_VERSION);    // all-ones counts, abandoned part way
    put_pack(32'hFFFF_FFFF);
    put_frame(TAG_SIZE, TAG_XYZI, 32'hFFFF_FFFF);
    put_junk(9);
    send_file(-1);
    start_file(VOX_VERSION);
    put_frame(TAG_SIZE, TAG_XYZI, 0);
    send_file(-1);
    send_noise(1, 1'b0);
  endtask

  task automatic test_offset_extremes();
    logic [15:0] ox[2], oy[2], oz[2];
    ox = '{16'h7FFF, 16'h8000};
    oy = '{16'h8000, 16'h7FFF};
    oz = '{16'hFFFF, 16'h0001};
    for (int k = 0; k < 2; k++) begin
      set_offsets(ox[k], oy[k], oz[k]);
      start_file(VOX_VERSION);
      put_frame(TAG_SIZE, TAG_XYZI, 3);
      put_voxel(8'hFF, 8'hFF, 8'hFF, 8'h01);
      put_voxel(8'h00, 8'h00, 8'h00, 8'h02);
      put_voxel(8'h80, 8'h7F, 8'h01, 8'h03);
      send_file(-1);
      send_noise(1, 1'b0);
    end
  endtask

  task automatic test_random_files(input int target);
    int stop_at, next_cfg, pause_at;
    stop_at  = bytes_sent + target;
    next_cfg = bytes_sent + 100;
    while (bytes_sent < stop_at) begin
      if (bytes_sent >= next_cfg) begin
        next_cfg = bytes_sent + 100;
        send_noise(1, 1'b0);  // let any pending done out first
        set_offsets(pick_offset(), pick_offset(), pick_offset());
      end
      if ($urandom_range(0, 7) == 0) send_noise($urandom_range(1, 5), 1'b1);
      build_random_file();
      pause_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, file_q.size() - 1) : -1;
      send_file(pause_at);
    end
  endtask

  // back-to-back transfers with the receiver always ready
  task automatic test_unstalled_tail(input int target);
    int stop_at;
    quiet   = 1'b1;
    stop_at = bytes_sent + target;
    while (bytes_sent < stop_at) begin
      build_random_file();
      send_file(-1);
    end
    send_noise(1, 1'b0);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_OFFSET_X;
    cfg_wdata = '0;
    offs      = '0;
    clear_parse();
    ph = PH_IDLE;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_basic_frame();
    test_header_errors();
    test_chunk_errors();
    test_frame_counts();
    test_offset_extremes();
    test_random_files(250);
    test_unstalled_tail(100);

    quiesce(0);
    repeat (8) @(negedge clk);
    if (expected_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_results.size()));

    $display("run: %0d bytes in %0d files, %0d results checked, %0d failures", bytes_sent,
             files_sent, results_seen, errors);
    $display("run: voxel, frame header, done and every error kind under changing offsets");
    if (errors == 0) begin
      $display("** vox_voxel_stream_parser_unit: PASSED **");
    end else begin
      $display("** vox_voxel_stream_parser_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/vox_pkg.sv
design/vox_parser_front.sv
design/vox_cmd_fifo.sv
design/vox_result_back.sv
design/vox_voxel_stream_parser_unit.sv
tb/sv/testbench.sv
